FILE: src/stt_pkg.sv
// Shared types, constants and codes for the software timer table.
package stt_pkg;

   localparam int SLOTS  = 8;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ID_W   = 8;
   localparam int TICK_W = 16;

   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_STOP  = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;
   localparam logic [1:0] STATUS_NOSTART = 2'd3;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FIRE   = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]   task_id;
      logic [TICK_W-1:0] reload;
      logic [TICK_W-1:0] remaining;
      logic              periodic;
   } entry_type;

   typedef struct packed {
      logic              set_en;
      logic [SLOT_W-1:0] set_idx;
      logic [ID_W-1:0]   set_id;
      logic              clear_en;
      logic [ID_W-1:0]   clear_id;
   } slot_op_type;

endpackage

FILE: src/stt_slot_ram.sv
// Slot entry memory: one write port, one registered read port.
module stt_slot_ram
   import stt_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [SLOT_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem [SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/stt_id_row.sv
// Slot valid bits, task identifier row, clear-by-identifier and free slot search.
module stt_id_row
   import stt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  slot_op_type       slot_op,
   output logic [SLOTS-1:0]  valid_vec,
   output logic              free_found,
   output logic [SLOT_W-1:0] free_idx
);

   logic [SLOTS-1:0] valid_ff;
   logic [SLOTS-1:0] valid_in;
   logic [ID_W-1:0]  task_ff [SLOTS];

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         valid_in[i] = valid_ff[i];
         if (slot_op.clear_en && valid_ff[i] && (task_ff[i] == slot_op.clear_id)) begin
            valid_in[i] = 1'b0;
         end
         if (slot_op.set_en && (slot_op.set_idx == SLOT_W'(i))) begin
            valid_in[i] = 1'b1;
         end
      end
   end

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_op.set_en) begin
         task_ff[slot_op.set_idx] <= slot_op.set_id;
      end
   end

   assign valid_vec = valid_ff;

endmodule

FILE: src/software_timer_table.sv
// Top level of the software timer table: item sequencer, tick walk and result register.
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------------------
//   req     | in        | req_func, req_task_id, req_delay_ticks, req_periodic
//   rsp     | out       | rsp_kind, rsp_status, rsp_fired_id, rsp_fired_slot, rsp_last
//
// Start, stop and unknown items go through accept, then the status item.
// A tick walks one slot per cycle through the entry memory's read port, then
// gives the closing status item; each fire item that finds the result
// register full holds the walk for as long as rsp_ready stays low.
// Reset clears all valid bits at once; no clearing pass is needed.
module software_timer_table
   import stt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [ID_W-1:0]   req_task_id,
   input  logic [TICK_W-1:0] req_delay_ticks,
   input  logic              req_periodic,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [1:0]        rsp_status,
   output logic [ID_W-1:0]   rsp_fired_id,
   output logic [2:0]        rsp_fired_slot,
   output logic              rsp_last
);

   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [1:0]        status_ff, status_in;
   logic              ever_ff, ever_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [2:0]        rsp_slot_ff, rsp_slot_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_load;

   logic              req_fire;
   logic              out_free;
   logic              walk_valid;
   logic [TICK_W-1:0] remain_dec;
   logic              hit;
   logic              advance;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [SLOT_W-1:0] rd_addr;
   entry_type         rd_entry;

   slot_op_type       slot_op;
   logic [SLOTS-1:0]  valid_vec;
   logic              free_found;
   logic [SLOT_W-1:0] free_idx;

   stt_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   stt_id_row u_row (
      .clock      (clock),
      .reset      (reset),
      .slot_op    (slot_op),
      .valid_vec  (valid_vec),
      .free_found (free_found),
      .free_idx   (free_idx)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign walk_valid = valid_vec[idx_ff];
   assign remain_dec = rd_entry.remaining - 1'b1;
   assign hit        = walk_valid && (remain_dec == '0);
   assign advance    = !hit || out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (req_func == FUNC_TICK) ? S_WALK : S_REPLY;
            end
         end
         S_WALK: begin
            if (advance && (idx_ff == LAST_IDX)) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_entry;
      rd_addr       = idx_ff;
      slot_op       = '0;
      status_in     = status_ff;
      ever_in       = ever_ff;
      idx_in        = idx_ff;
      rsp_load      = 1'b0;
      rsp_kind_in   = KIND_STATUS;
      rsp_status_in = STATUS_OK;
      rsp_id_in     = '0;
      rsp_slot_in   = '0;
      rsp_last_in   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            idx_in  = '0;
            if (req_fire) begin
               case (req_func)
                  FUNC_START: begin
                     if (req_delay_ticks == '0) begin
                        status_in = STATUS_INVALID;
                     end else if (!free_found) begin
                        status_in = STATUS_FULL;
                     end else begin
                        status_in         = STATUS_OK;
                        wr_en             = 1'b1;
                        wr_addr           = free_idx;
                        wr_data.task_id   = req_task_id;
                        wr_data.reload    = req_delay_ticks;
                        wr_data.remaining = req_delay_ticks;
                        wr_data.periodic  = req_periodic;
                        slot_op.set_en    = 1'b1;
                        slot_op.set_idx   = free_idx;
                        slot_op.set_id    = req_task_id;
                        ever_in           = 1'b1;
                     end
                  end
                  FUNC_STOP: begin
                     if (!ever_ff) begin
                        status_in = STATUS_NOSTART;
                     end else begin
                        status_in        = STATUS_OK;
                        slot_op.clear_en = 1'b1;
                        slot_op.clear_id = req_task_id;
                     end
                  end
                  FUNC_TICK: begin
                     status_in = STATUS_OK;
                  end
                  default: begin
                     status_in = STATUS_INVALID;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (advance) begin
               idx_in  = SLOT_W'(idx_ff + 1'b1);
               rd_addr = SLOT_W'(idx_ff + 1'b1);
               if (walk_valid) begin
                  wr_en             = 1'b1;
                  wr_data.remaining = (hit && rd_entry.periodic) ? rd_entry.reload : remain_dec;
               end
               if (hit) begin
                  rsp_load    = 1'b1;
                  rsp_kind_in = KIND_FIRE;
                  rsp_id_in   = rd_entry.task_id;
                  rsp_slot_in = 3'(idx_ff);
                  if (!rd_entry.periodic) begin
                     slot_op.clear_en = 1'b1;
                     slot_op.clear_id = rd_entry.task_id;
                  end
               end
            end
         end
         S_REPLY: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         ever_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         ever_ff      <= ever_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fired_id   = rsp_id_ff;
   assign rsp_fired_slot = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTH
   a_walk_ends : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && advance && idx_ff == LAST_IDX) |=> (state_ff == S_REPLY))
      else $error("tick walk did not close with a status item");

   a_fire_not_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_FIRE) |-> !rsp_last_ff)
      else $error("fire item marked as last");

   a_tick_starts : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_func == FUNC_TICK) |=> (state_ff == S_WALK && idx_ff == '0))
      else $error("tick item did not start the walk at slot zero");

   a_set_free : assert property (@(posedge clock) disable iff (reset)
      slot_op.set_en |-> !valid_vec[slot_op.set_idx])
      else $error("start placed into an occupied slot");
`endif

endmodule
